### sv/hsl_pkg.sv
// ============================================================================
// hsl_pkg - shared types and constants for the HSL to RGB converter
// Holds the fixed-point constants of the rounding divider and the sextant codes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package hsl_pkg;

    // Common denominator 2*255*255 and its half for round-half-up
    localparam logic [16:0] HSL_DEN  = 17'd130050;
    localparam logic [16:0] HSL_HALF = 17'd65025;

    // floor(x / HSL_DEN) == (x * HSL_RECIP) >> HSL_SHIFT, exact for x < 2**HSL_XW
    localparam int          HSL_XW    = 25;
    localparam int          HSL_SHIFT = 42;
    localparam logic [25:0] HSL_RECIP =
        26'(((64'd1 << HSL_SHIFT) + 64'd130049) / 64'd130050);

    // Signed numerator width, wide enough for every channel numerator
    typedef logic signed [27:0] num_t;

    typedef enum logic [2:0] {
        SEXT_0 = 3'd0,
        SEXT_1 = 3'd1,
        SEXT_2 = 3'd2,
        SEXT_3 = 3'd3,
        SEXT_4 = 3'd4,
        SEXT_5 = 3'd5
    } sext_t;

endpackage : hsl_pkg

`default_nettype wire

### sv/hsl_to_rgb_8bit_top.sv
// ============================================================================
// hsl_to_rgb_8bit_top - HSL to RGB color converter, 8 bits per channel
// Four-stage pipeline: sextant and chroma, channel numerators, rounding
// divide by a reciprocal multiply, clamp and channel routing.
// ============================================================================
// Usage:
//   Input stream (s_*): one color per transaction, s_tdata packs hue [7:0],
//   saturation [15:8], lightness [23:16].
//   Output stream (m_*): one color per transaction, m_tdata packs red [7:0],
//   green [15:8], blue [23:16].
//   Every input transaction produces exactly one output transaction, in order.
//   m_tvalid rises when the color reaches the stage 4 register, after stages 1
//   to 3. Throughput is one color per clock while the output is not stalled; the
//   four register stages each hold one color, so up to four colors are in flight.
//   Each stage carries its own valid bit and advances when the stage ahead is
//   empty or moving, so bubbles collapse while the output is stalled and
//   s_tready only drops once all four stages are full.
//   A stalled output holds m_tdata steady; nothing is dropped or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline; there is no other
//   state and no setup is needed before the first color.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsl_to_rgb_8bit_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // hue[7:0], saturation[15:8], lightness[23:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import hsl_pkg::*;

    // ---------------- handshake / valid chain ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: sextant, chroma product ----------------
    logic [7:0]  hue, saturation, lightness;
    logic [10:0] hx6;
    logic [2:0]  kcnt;
    logic [10:0] rem11;
    logic [7:0]  rem;
    logic [7:0]  sec;
    logic [7:0]  amp;
    sext_t       k_next;
    logic [15:0] p_next;
    logic signed [9:0] gs_next;

    sext_t       k1_reg;
    logic [15:0] p1_reg;
    logic signed [9:0] gs1_reg;
    logic [7:0]  l1_reg;

    assign hue        = s_tdata[7:0];
    assign saturation = s_tdata[15:8];
    assign lightness  = s_tdata[23:16];

    always_comb begin
        hx6   = 11'(hue) * 11'd6;
        kcnt  = 3'(hx6 >= 11'd255) + 3'(hx6 >= 11'd510) + 3'(hx6 >= 11'd765)
              + 3'(hx6 >= 11'd1020) + 3'(hx6 >= 11'd1275);
        rem11 = hx6 - (11'(kcnt) * 11'd255);
        rem   = rem11[7:0];
        // full-circle hue wraps back to the start of sextant 0
        if (hx6 == 11'd1530) begin
            kcnt = 3'd0;
            rem  = 8'd0;
        end
        k_next = sext_t'(kcnt);
        sec    = kcnt[0] ? (8'd255 - rem) : rem;
        gs_next = signed'({1'b0, sec, 1'b0}) - 10'sd255;
        // 255 - |2l - 255|
        amp    = lightness[7] ? 8'(9'd510 - {lightness, 1'b0}) : {lightness[6:0], 1'b0};
        p_next = 16'(amp) * 16'(saturation);
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            k1_reg  <= k_next;
            p1_reg  <= p_next;
            gs1_reg <= gs_next;
            l1_reg  <= lightness;
        end
    end

    // ---------------- stage 2: channel numerators plus half ----------------
    num_t  base, pch, psec;
    num_t  xc_next, xs_next, xz_next;
    num_t  xc2_reg, xs2_reg, xz2_reg;
    sext_t k2_reg;

    always_comb begin
        base    = num_t'(l1_reg) * num_t'(HSL_DEN) + num_t'(HSL_HALF);
        pch     = num_t'(p1_reg) * num_t'(255);
        psec    = num_t'(p1_reg) * num_t'(gs1_reg);
        xc_next = base + pch;
        xs_next = base + psec;
        xz_next = base - pch;
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            xc2_reg <= xc_next;
            xs2_reg <= xs_next;
            xz2_reg <= xz_next;
            k2_reg  <= k1_reg;
        end
    end

    // ---------------- stage 3: reciprocal multiply ----------------
    logic [50:0] qc_prod, qs_prod, qz_prod;
    logic [8:0]  qc3_reg, qs3_reg, qz3_reg;
    logic        nc3_reg, ns3_reg, nz3_reg;
    logic        oc3_reg, os3_reg, oz3_reg;
    sext_t       k3_reg;

    always_comb begin
        qc_prod = 51'(xc2_reg[HSL_XW-1:0]) * 51'(HSL_RECIP);
        qs_prod = 51'(xs2_reg[HSL_XW-1:0]) * 51'(HSL_RECIP);
        qz_prod = 51'(xz2_reg[HSL_XW-1:0]) * 51'(HSL_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            qc3_reg <= qc_prod[50:42];
            qs3_reg <= qs_prod[50:42];
            qz3_reg <= qz_prod[50:42];
            nc3_reg <= xc2_reg[27];
            ns3_reg <= xs2_reg[27];
            nz3_reg <= xz2_reg[27];
            oc3_reg <= |xc2_reg[26:25];
            os3_reg <= |xs2_reg[26:25];
            oz3_reg <= |xz2_reg[26:25];
            k3_reg  <= k2_reg;
        end
    end

    // ---------------- stage 4: clamp and route ----------------
    function automatic logic [7:0] sat8(input logic neg, input logic ovf,
                                        input logic [8:0] q);
        logic [7:0] res;
        if (neg)
            res = 8'd0;
        else if (ovf || q[8])
            res = 8'd255;
        else
            res = q[7:0];
        return res;
    endfunction

    logic [7:0]  ch_c, ch_s, ch_z;
    logic [23:0] rgb_next;
    logic [23:0] rgb_reg;

    always_comb begin
        ch_c = sat8(nc3_reg, oc3_reg, qc3_reg);
        ch_s = sat8(ns3_reg, os3_reg, qs3_reg);
        ch_z = sat8(nz3_reg, oz3_reg, qz3_reg);
        case (k3_reg)
            SEXT_0:  rgb_next = {ch_z, ch_s, ch_c};
            SEXT_1:  rgb_next = {ch_z, ch_c, ch_s};
            SEXT_2:  rgb_next = {ch_s, ch_c, ch_z};
            SEXT_3:  rgb_next = {ch_c, ch_s, ch_z};
            SEXT_4:  rgb_next = {ch_c, ch_z, ch_s};
            default: rgb_next = {ch_s, ch_z, ch_c};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            rgb_reg <= rgb_next;
        end
    end

    assign m_tdata = rgb_reg;

endmodule : hsl_to_rgb_8bit_top

`default_nettype wire

### sv/hsl_checker.sv
// ============================================================================
// hsl_checker - port-level checks for the HSL to RGB converter
// Watches the stream ports of the top level; attached by a bind below.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsl_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set right after reset");

    // a stalled output transaction holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // an empty output stage means the pipeline has room
    a_room_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output stage");

    // a draining output never back-pressures the input
    a_ready_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    // input data is not otherwise checked here
    logic unused_in;
    assign unused_in = s_tvalid ^ (^s_tdata);

endmodule : hsl_checker

bind hsl_to_rgb_8bit_top hsl_checker u_hsl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/hsl_to_rgb_checker.sv
// ============================================================================
// hsl_to_rgb_checker - scoreboard for the HSL to RGB converter
// Watches both stream channels, predicts the color of every accepted input
// transaction and compares each output transaction with the oldest one.
// ============================================================================
`timescale 1ns / 1ps

module hsl_to_rgb_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // hue[7:0], saturation[15:8], lightness[23:16]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // red[7:0], green[15:8], blue[23:16]
    output int          fail_count,
    output int          pending,
    output int          colors_checked
);

    import hsl_pkg::*;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    rgb_t expected_rgb[$];

    initial begin
        fail_count     = 0;
        pending        = 0;
        colors_checked = 0;
    end

    // Round half up over the common denominator, clamped to 0..255
    function automatic logic [7:0] round_channel(longint num);
        longint v;
        if (num < 0) return 8'd0;
        v = (num + longint'(HSL_HALF)) / longint'(HSL_DEN);
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic rgb_t rgb_from_hsl(logic [7:0] hue, logic [7:0] sat,
                                          logic [7:0] light);
        longint h, s, l, dev, span, prod, pos, rem, ramp, base;
        logic [7:0] chroma, second, floor_v;
        sext_t sext;
        rgb_t c;
        h    = hue;
        s    = sat;
        l    = light;
        dev  = 2 * l - 255;
        span = 255 - (dev < 0 ? -dev : dev);
        prod = span * s;
        pos  = (6 * h) / 255;
        rem  = (6 * h) % 255;
        // hue 255 wraps around to the start of the red sextant
        if (pos >= 6) begin
            pos = 0;
            rem = 0;
        end
        sext    = sext_t'(pos[2:0]);
        ramp    = pos[0] ? 255 - rem : rem;
        base    = l * longint'(HSL_DEN);
        chroma  = round_channel(prod * 255 + base);
        second  = round_channel(prod * (2 * ramp - 255) + base);
        floor_v = round_channel(base - prod * 255);
        case (sext)
            SEXT_0: c = '{red: chroma,  green: second,  blue: floor_v};
            SEXT_1: c = '{red: second,  green: chroma,  blue: floor_v};
            SEXT_2: c = '{red: floor_v, green: chroma,  blue: second};
            SEXT_3: c = '{red: floor_v, green: second,  blue: chroma};
            SEXT_4: c = '{red: second,  green: floor_v, blue: chroma};
            default: c = '{red: chroma, green: floor_v, blue: second};
        endcase
        return c;
    endfunction

    always @(posedge aclk) begin
        rgb_t want;
        rgb_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_rgb.push_back(rgb_from_hsl(s_tdata[7:0], s_tdata[15:8],
                                                    s_tdata[23:16]));
            if (m_tvalid && m_tready) begin
                got = rgb_t'(m_tdata);
                if (expected_rgb.size() == 0) begin
                    $error("unexpected output transaction 0x%06h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_rgb.pop_front();
                    colors_checked++;
                    if (got.red !== want.red) begin
                        $error("red: expected %0d, actual %0d", want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("green: expected %0d, actual %0d", want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                        fail_count++;
                    end
                end
            end
            pending = expected_rgb.size();
        end
    end

endmodule

### tb/tb_hsl_to_rgb_8bit_top.sv
// ============================================================================
// tb_hsl_to_rgb_8bit_top - testbench for the HSL to RGB converter
// Drives directed corner colors and then random colors through the input
// stream with random idle bursts on both sides, a long output stall and a
// full drain; the checker predicts and compares every output color.
// ============================================================================
`timescale 1ns / 1ps

module tb_hsl_to_rgb_8bit_top;

    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_ITEMS = 1950;
    localparam int CALM_FROM    = 1700;
    localparam int HOLD_AT      = 500;
    localparam int PAUSE_AT     = 1100;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT_CYCLES = 400000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = 24'd0;   // hue[7:0], saturation[15:8], lightness[23:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // red[7:0], green[15:8], blue[23:16]

    int fail_count;
    int pending;
    int colors_checked;
    int colors_sent = 0;
    bit calm        = 1'b0;
    bit stall_hold  = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    hsl_to_rgb_8bit_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hsl_to_rgb_checker scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .colors_checked (colors_checked)
    );

    task automatic send_color(input logic [7:0] hue, input logic [7:0] sat,
                              input logic [7:0] light);
        s_tvalid <= 1'b1;
        s_tdata  <= {light, sat, hue};
        do @(posedge aclk); while (!s_tready);
        colors_sent++;
    endtask

    task automatic sender_idle(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Mostly uniform, sometimes a value at or next to a range boundary
    function automatic logic [7:0] pick_level();
        logic [7:0] corners[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        if ($urandom_range(0, 4) == 0)
            return corners[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Output side: random stall bursts, one long hold on request
    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (stall_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                stall_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: black, white, grays, full saturation at mid
        // lightness, every sextant boundary and the wrapping hue of 255
        send_color(8'd0,   8'd0,   8'd0);
        send_color(8'd255, 8'd255, 8'd255);
        send_color(8'd0,   8'd255, 8'd0);
        send_color(8'd0,   8'd255, 8'd255);
        send_color(8'd100, 8'd0,   8'd128);
        send_color(8'd0,   8'd255, 8'd127);
        send_color(8'd0,   8'd255, 8'd128);
        send_color(8'd42,  8'd255, 8'd128);
        send_color(8'd43,  8'd255, 8'd128);
        send_color(8'd85,  8'd255, 8'd127);
        send_color(8'd86,  8'd255, 8'd128);
        send_color(8'd127, 8'd255, 8'd128);
        send_color(8'd128, 8'd255, 8'd127);
        send_color(8'd170, 8'd255, 8'd128);
        send_color(8'd171, 8'd200, 8'd60);
        sender_idle(3);
        send_color(8'd212, 8'd255, 8'd128);
        send_color(8'd213, 8'd255, 8'd127);
        send_color(8'd254, 8'd255, 8'd128);
        send_color(8'd255, 8'd255, 8'd128);
        send_color(8'd255, 8'd1,   8'd1);
        send_color(8'd255, 8'd128, 8'd254);
        send_color(8'd170, 8'd255, 8'd255);
        send_color(8'd1,   8'd1,   8'd127);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == CALM_FROM) calm = 1'b1;
            if (n == HOLD_AT) stall_hold = 1'b1;
            if (n == PAUSE_AT) begin
                s_tvalid <= 1'b0;
                // let the scoreboard see the last accepted color before waiting for it to drain
                @(posedge aclk);
                wait (pending == 0);
                @(posedge aclk);
            end
            send_color(pick_level(), pick_level(), pick_level());
            // keep offering back to back while the output is held off
            if (!calm && !stall_hold && $urandom_range(0, 4) == 0)
                sender_idle($urandom_range(1, 13));
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d colors (corners, sextant edges, wrapping hue, random fill);",
                 colors_sent);
        $display("checked %0d outputs through idle bursts, a long stall and a drain.",
                 colors_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $error("timeout with %0d outputs still expected", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
sv/hsl_pkg.sv
sv/hsl_to_rgb_8bit_top.sv
sv/hsl_checker.sv
tb/hsl_to_rgb_checker.sv
tb/tb_hsl_to_rgb_8bit_top.sv
